// ===== sv/elqt_pkg.sv =====
// Shared types, constants and codes for the link quality tracker.
package elqt_pkg;

    // Quality format: unsigned fraction with Q_BITS fraction bits
    localparam int Q_BITS = 16;
    localparam logic [Q_BITS:0]   Q_ONE = (Q_BITS+1)'(1) << Q_BITS;
    localparam logic [Q_BITS-1:0] Q_MAX = {Q_BITS{1'b1}};
    localparam logic [Q_BITS:0]   ALPHA_WARMUP = Q_ONE >> 2;

    // Parameter defaults
    localparam int WARMUP_STEPS_DEF = 12;
    localparam int COST_SCALE_DEF   = 1024;

    // Field and register widths
    localparam int WARM_W     = 4;
    localparam int NQ_W       = 8;
    localparam int LOSS_W     = 17;
    localparam int COST_W     = 23;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 2;

    // Serial multiplier geometry
    localparam int MUL_W     = 17;
    localparam int MUL_DIGIT = 4;
    localparam int PROD_W    = 2 * MUL_W;

    // Divisor width: product of two qualities
    localparam int DIV_W = 2 * Q_BITS;

    // Register reset values
    localparam logic [Q_BITS-1:0] AGING_RATE_RST  = Q_BITS'(3277);
    localparam logic [LOSS_W-1:0] LOSS_MULT_RST   = LOSS_W'(65536);
    localparam logic [Q_BITS-1:0] MIN_QUALITY_RST = Q_BITS'(6554);
    localparam logic [COST_W-1:0] COST_LIMIT_RST  = COST_W'(4194304);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AGING_RATE  = 2'd0,
        CFG_LOSS_MULT   = 2'd1,
        CFG_MIN_QUALITY = 2'd2,
        CFG_COST_LIMIT  = 2'd3
    } cfg_index_t;

    // Event kinds carried on tuser
    localparam logic OP_HELLO  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECAY_WAIT,
        ST_GAIN_WAIT,
        ST_PROD_START,
        ST_PROD_WAIT,
        ST_DIV_WAIT,
        ST_RESULT
    } state_t;

    // Status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// ===== sv/elqt_mul.sv =====
// Digit-serial unsigned multiplier, one 4-bit digit of the second operand per cycle.
module elqt_mul
    import elqt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] product,
    output unit_status_t      status
);

    localparam int STEPS = (MUL_W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BP_W  = STEPS * MUL_DIGIT;
    localparam int CW    = $clog2(STEPS + 1);

    logic [MUL_W-1:0]  a_reg;
    logic [BP_W-1:0]   b_reg;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg, done_reg;

    logic [MUL_DIGIT-1:0]       digit;
    logic [MUL_W+MUL_DIGIT-1:0] partial;

    // Top digit first: shift accumulator, add a times digit
    assign digit    = b_reg[BP_W-1 -: MUL_DIGIT];
    assign partial  = {{MUL_DIGIT{1'b0}}, a_reg} * {{MUL_W{1'b0}}, digit};
    assign acc_next = (acc_reg << MUL_DIGIT)
                    + {{(PROD_W-MUL_W-MUL_DIGIT){1'b0}}, partial};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= {{(BP_W-MUL_W){1'b0}}, b};
            acc_reg <= '0;
        end else if (busy_reg) begin
            b_reg   <= b_reg << MUL_DIGIT;
            acc_reg <= acc_next;
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== sv/elqt_div.sv =====
// Restoring divider for the cost: COST_SCALE * 2^DIV_W over the divisor, one bit per cycle.
module elqt_div
    import elqt_pkg::*;
#(
    parameter int COST_SCALE = COST_SCALE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  divisor,
    output logic [COST_W-1:0] quotient,
    output logic              overflow,
    output unit_status_t      status
);

    // Leading zeros of the dividend never give quotient bits, so skip them
    localparam int SCALE_BITS = $clog2(COST_SCALE + 1);
    localparam int ITERS      = SCALE_BITS + DIV_W;
    localparam int CW         = $clog2(ITERS + 1);

    logic [SCALE_BITS-1:0] scale_reg;
    logic [DIV_W-1:0]      d_reg;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [COST_W-1:0]     q_reg;
    logic                  ovf_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg, done_reg;

    logic [DIV_W:0] rem_sh, d_ext, diff;
    logic           ge;

    // One restoring step
    assign rem_sh   = {rem_reg, scale_reg[SCALE_BITS-1]};
    assign d_ext    = {1'b0, d_reg};
    assign ge       = (rem_sh >= d_ext);
    assign diff     = rem_sh - d_ext;
    assign rem_next = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ITERS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend, remainder and quotient shift registers; a bit shifted off the
    // top of the quotient marks it as beyond any cost limit
    always_ff @(posedge aclk) begin
        if (start) begin
            scale_reg <= SCALE_BITS'(COST_SCALE);
            d_reg     <= divisor;
            rem_reg   <= '0;
            q_reg     <= '0;
            ovf_reg   <= 1'b0;
        end else if (busy_reg) begin
            scale_reg <= scale_reg << 1;
            rem_reg   <= rem_next;
            q_reg     <= {q_reg[COST_W-2:0], ge};
            ovf_reg   <= ovf_reg | q_reg[COST_W-1];
        end
    end

    assign quotient    = q_reg;
    assign overflow    = ovf_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== sv/etx_link_quality_tracker.sv =====
// Top level: link quality moving average and ETX cost for one link.
//
//  channel   direction  contents
//  s_*       in         tuser: op; tdata: lost, neighbor_quality, neighbor_present
//  m_*       out        tdata: link_cost, link_quality, broken
//  cfg_*     in         register write: index, data
//
// One event is in flight at a time; the next is accepted the cycle after the
// result is loaded. A received hello takes a decay and a gain product, a lost
// hello only the decay product, a report neither; every event then takes the
// link product and the divide. Each product runs on the 5-step radix-16
// multiplier; the divider runs clog2(COST_SCALE+1)+32 steps (43 at the default),
// one quotient bit per step. A broken link or a zero quality skips the link product and the divide.
// Reset is synchronous, active low, and sets state, link qualities, configuration and output valid.
// A result waits in the output register while the next event is accepted.
module etx_link_quality_tracker
    import elqt_pkg::*;
#(
    parameter int WARMUP_STEPS = WARMUP_STEPS_DEF,
    parameter int COST_SCALE   = COST_SCALE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input events
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // lost[0], neighbor_quality[8:1],
                                             // neighbor_present[9], zero[15:10]
    input  logic                  s_tuser,   // op[0]
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // link_cost[22:0], link_quality[38:23],
                                             // broken[39]
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic [Q_BITS-1:0] aging_reg;
    logic [LOSS_W-1:0] loss_reg;
    logic [Q_BITS-1:0] minq_reg;
    logic [COST_W-1:0] limit_reg;

    // Link state
    state_t            state_reg, state_next;
    logic [WARM_W-1:0] warmup_reg;
    logic [Q_BITS-1:0] lq_reg;
    logic [Q_BITS-1:0] nlq_reg;

    // Per-event registers
    logic [Q_BITS:0]   alpha_reg;
    logic              lost_reg;
    logic              brk_reg;
    logic [COST_W-1:0] cost_reg;
    logic [39:0]       m_tdata_reg;
    logic              m_tvalid_reg;

    // Input fields
    logic            in_op, in_lost, in_present;
    logic [NQ_W-1:0] in_nq;

    // Arithmetic units
    logic              mul_start, div_start;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_prod;
    unit_status_t      mul_st, div_st;
    logic [COST_W-1:0] div_q;
    logic              div_ovf;

    logic              accept, load_out;
    logic              warm_active;
    logic [Q_BITS:0]   alpha_now, one_minus;
    logic              brk_now, zero_now;
    logic [Q_BITS-1:0] decay_val;
    logic [Q_BITS:0]   gain_val;
    logic [Q_BITS+1:0] sum_val;
    logic [Q_BITS-1:0] sum_sat;
    logic [COST_W-1:0] div_cost, div_cost_clamped;

    assign in_op      = s_tuser;
    assign in_lost    = s_tdata[0];
    assign in_nq      = s_tdata[8:1];
    assign in_present = s_tdata[9];

    // Alpha: fixed quarter during warmup, aging rate afterwards
    assign warm_active = (warmup_reg < WARM_W'(WARMUP_STEPS));
    assign alpha_now   = warm_active ? ALPHA_WARMUP : {1'b0, aging_reg};
    assign one_minus   = Q_ONE - alpha_now;

    // Hello arithmetic on the multiplier result
    assign decay_val = mul_prod[2*Q_BITS-1 : Q_BITS];
    assign gain_val  = mul_prod[Q_BITS +: Q_BITS+1];
    assign sum_val   = {2'b00, lq_reg} + {1'b0, gain_val};
    assign sum_sat   = (sum_val > {2'b00, Q_MAX}) ? Q_MAX : sum_val[Q_BITS-1:0];

    // Broken and zero-product tests
    assign brk_now  = (lq_reg < minq_reg) || (nlq_reg < minq_reg);
    assign zero_now = (lq_reg == '0) || (nlq_reg == '0);

    // Quotient clamped to the limit, never below one
    assign div_cost         = (div_ovf || (div_q > limit_reg)) ? limit_reg : div_q;
    assign div_cost_clamped = (div_cost == '0) ? COST_W'(1) : div_cost;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (in_op == OP_HELLO) ? ST_DECAY_WAIT : ST_PROD_START;
                end
            end
            ST_DECAY_WAIT: begin
                if (mul_st.done) begin
                    state_next = lost_reg ? ST_PROD_START : ST_GAIN_WAIT;
                end
            end
            ST_GAIN_WAIT: begin
                if (mul_st.done) begin
                    state_next = ST_PROD_START;
                end
            end
            ST_PROD_START: begin
                state_next = (brk_now || zero_now) ? ST_RESULT : ST_PROD_WAIT;
            end
            ST_PROD_WAIT: begin
                if (mul_st.done) begin
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_st.done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        accept    = s_tvalid && s_tready;
        mul_start = 1'b0;
        mul_a     = {1'b0, lq_reg};
        mul_b     = one_minus;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                mul_start = accept && (in_op == OP_HELLO);
            end
            ST_DECAY_WAIT: begin
                mul_start = mul_st.done && !lost_reg;
                mul_a     = alpha_reg;
                mul_b     = loss_reg;
            end
            ST_PROD_START: begin
                mul_start = !(brk_now || zero_now);
                mul_b     = {1'b0, nlq_reg};
            end
            ST_PROD_WAIT: begin
                div_start = mul_st.done;
            end
            ST_RESULT: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            ST_GAIN_WAIT, ST_DIV_WAIT: begin
            end
            default: begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aging_reg <= AGING_RATE_RST;
            loss_reg  <= LOSS_MULT_RST;
            minq_reg  <= MIN_QUALITY_RST;
            limit_reg <= COST_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_AGING_RATE:  aging_reg <= cfg_wdata[Q_BITS-1:0];
                CFG_LOSS_MULT:   loss_reg  <= cfg_wdata[LOSS_W-1:0];
                CFG_MIN_QUALITY: minq_reg  <= cfg_wdata[Q_BITS-1:0];
                CFG_COST_LIMIT:  limit_reg <= cfg_wdata[COST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state and link qualities
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            warmup_reg   <= '0;
            lq_reg       <= '0;
            nlq_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // warmup counts hellos only and stops at the limit
            if (accept && (in_op == OP_HELLO) && warm_active) begin
                warmup_reg <= warmup_reg + WARM_W'(1);
            end
            // report: byte/255 in Q0.16 is the byte repeated in both halves
            if (accept && (in_op == OP_REPORT)) begin
                nlq_reg <= in_present ? {in_nq, in_nq} : '0;
            end
            if (state_reg == ST_DECAY_WAIT && mul_st.done) begin
                lq_reg <= decay_val;
            end else if (state_reg == ST_GAIN_WAIT && mul_st.done) begin
                lq_reg <= sum_sat;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Per-event payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            alpha_reg <= alpha_now;
            lost_reg  <= in_lost;
        end
        if (state_reg == ST_PROD_START) begin
            brk_reg <= brk_now;
            if (brk_now) begin
                cost_reg <= limit_reg;
            end else begin
                cost_reg <= (limit_reg == '0) ? COST_W'(1) : limit_reg;
            end
        end else if (state_reg == ST_DIV_WAIT && div_st.done) begin
            cost_reg <= div_cost_clamped;
        end
        if (load_out) begin
            m_tdata_reg <= {brk_reg, lq_reg, cost_reg};
        end
    end

    elqt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_prod),
        .status  (mul_st)
    );

    elqt_div #(
        .COST_SCALE (COST_SCALE)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (mul_prod[DIV_W-1:0]),
        .quotient (div_q),
        .overflow (div_ovf),
        .status   (div_st)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The multiplier and the divider never run at the same time
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_st.busy && div_st.busy))
        else $error("multiplier and divider busy together");

    // A finished result waits while the output register is still occupied
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_RESULT))
        else $error("result overwrote a pending transaction");

    // A working link never reports a zero cost
    a_cost_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[39]) |-> (m_tdata[22:0] != '0))
        else $error("zero cost on a working link");

    // Warmup counter stops at its limit
    a_warmup_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        warmup_reg <= WARM_W'(WARMUP_STEPS))
        else $error("warmup counter past its limit");

endmodule

// ===== dv/etx_link_quality_tracker_test.sv =====
// Self-checking stream testbench for the link quality tracker (EWMA quality and ETX cost).
module etx_link_quality_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;
    import elqt_pkg::*;

    // One expected result transaction
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [Q_BITS-1:0] quality;
        logic              brk;
    } link_result_t;

    // Mirrors the tracker state and keeps the results still owed by the block
    class link_cost_predictor;
        logic [Q_BITS-1:0] aging_rate;
        logic [LOSS_W-1:0] loss_mult;
        logic [Q_BITS-1:0] min_quality;
        logic [COST_W-1:0] cost_limit;
        logic [Q_BITS-1:0] lq;
        logic [Q_BITS-1:0] nlq;
        int                warm_count;
        link_result_t      awaited[$];
        int                errors;

        function new();
            aging_rate  = AGING_RATE_RST;
            loss_mult   = LOSS_MULT_RST;
            min_quality = MIN_QUALITY_RST;
            cost_limit  = COST_LIMIT_RST;
            lq          = '0;
            nlq         = '0;
            warm_count  = 0;
            errors      = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_AGING_RATE:  aging_rate  = v[Q_BITS-1:0];
                CFG_LOSS_MULT:   loss_mult   = v[LOSS_W-1:0];
                CFG_MIN_QUALITY: min_quality = v[Q_BITS-1:0];
                CFG_COST_LIMIT:  cost_limit  = v[COST_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted event and queue the result it must produce
        function void note_event(logic op, logic lost, logic [7:0] nq, logic present);
            logic [Q_BITS:0] alpha;
            logic [63:0]     acc;
            logic [63:0]     prod;
            link_result_t    r;
            if (op == OP_HELLO) begin
                // fixed 0.25 during warmup, configured rate afterwards
                if (warm_count < WARMUP_STEPS_DEF) begin
                    alpha = ALPHA_WARMUP;
                    warm_count++;
                end else begin
                    alpha = {1'b0, aging_rate};
                end
                acc = (64'(lq) * (64'(Q_ONE) - 64'(alpha))) >> Q_BITS;
                if (!lost) begin
                    acc += (64'(alpha) * 64'(loss_mult)) >> 16;
                    if (acc > 64'(Q_MAX))
                        acc = 64'(Q_MAX);
                end
                lq = acc[Q_BITS-1:0];
            end else if (present) begin
                acc = (64'(nq) << Q_BITS) / 64'd255;
                nlq = (acc > 64'(Q_MAX)) ? Q_MAX : acc[Q_BITS-1:0];
            end else begin
                nlq = '0;
            end

            r.quality = lq;
            r.brk     = (lq < min_quality) || (nlq < min_quality);
            prod      = 64'(lq) * 64'(nlq);
            if (r.brk) begin
                // broken link reports the limit as is, even a zero limit
                acc = 64'(cost_limit);
            end else begin
                acc = (prod == 0) ? 64'(cost_limit)
                                  : (64'(COST_SCALE_DEF) << (2 * Q_BITS)) / prod;
                if (acc > 64'(cost_limit))
                    acc = 64'(cost_limit);
                if (acc == 0)
                    acc = 64'd1;
            end
            r.cost = acc[COST_W-1:0];
            awaited.push_back(r);
        endfunction

        // Compare one result transaction against the oldest expectation
        function void check_result(logic [39:0] data);
            link_result_t      want;
            logic [COST_W-1:0] cost;
            logic [Q_BITS-1:0] quality;
            logic              brk;
            cost    = data[22:0];
            quality = data[38:23];
            brk     = data[39];
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, tdata %h", $time, data);
                return;
            end
            want = awaited.pop_front();
            if (cost !== want.cost) begin
                errors++;
                $display("%0t: link_cost expected %0d, actual %0d", $time, want.cost, cost);
            end
            if (quality !== want.quality) begin
                errors++;
                $display("%0t: link_quality expected %0d, actual %0d",
                         $time, want.quality, quality);
            end
            if (brk !== want.brk) begin
                errors++;
                $display("%0t: broken expected %0b, actual %0b", $time, want.brk, brk);
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // lost[0], neighbor_quality[8:1],
                                             // neighbor_present[9], zero[15:10]
    logic                  s_tuser   = 1'b0; // op[0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;          // link_cost[22:0], link_quality[38:23],
                                             // broken[39]
    logic                  cfg_wr_en = 1'b0;
    cfg_index_t            cfg_index = CFG_AGING_RATE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bit calm       = 1'b0;   // no idling on either side
    bit hold_asked = 1'b0;   // receiver should hold off once
    bit hold_done  = 1'b0;
    int hold_left  = 0;

    link_cost_predictor cost_pred = new();

    etx_link_quality_tracker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Result side: check each transaction, then pick the next tready
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            cost_pred.check_result(m_tdata);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_asked && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // Offer one event, with a random gap before it, and wait for acceptance
    task automatic send_event(logic op, logic lost, logic [7:0] nq, logic present);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 22)
            gap = ($urandom_range(3) == 0) ? $urandom_range(70, 1) : $urandom_range(4, 1);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, present, nq, lost};
        do @(posedge aclk); while (!s_tready);
        cost_pred.note_event(op, lost, nq, present);
    endtask

    // Stop offering and wait until every expected result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (cost_pred.pending() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // Write all four registers, one per cycle; block must be idle
    task automatic load_registers(int unsigned aging, int unsigned loss,
                                  int unsigned minq, int unsigned limit);
        cfg_index_t            regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_AGING_RATE, CFG_LOSS_MULT, CFG_MIN_QUALITY, CFG_COST_LIMIT};
        vals = '{CFG_DATA_W'(aging), CFG_DATA_W'(loss), CFG_DATA_W'(minq),
                 CFG_DATA_W'(limit)};
        for (int k = 0; k < 4; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[k];
            cfg_wdata <= vals[k];
            cost_pred.write_reg(regs[k], vals[k]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Random mix, mostly hellos; optionally pauses halfway until drained
    task automatic random_burst(int count, bit pause_mid);
        for (int k = 0; k < count; k++) begin
            if (pause_mid && k == count / 2)
                drain();
            send_event(($urandom_range(99) < 35) ? OP_REPORT : OP_HELLO,
                       $urandom_range(99) < 30, 8'($urandom),
                       $urandom_range(99) < 85);
        end
        drain();
    endtask

    // Common short directed set used after most register changes
    task automatic poke_extremes();
        send_event(OP_REPORT, 1'b1, 8'h5A, 1'b0);   // neighbor absent
        send_event(OP_HELLO,  1'b1, 8'hFF, 1'b1);   // lost hello
        send_event(OP_HELLO,  1'b0, 8'h00, 1'b0);
        send_event(OP_HELLO,  1'b0, 8'hA5, 1'b1);
        send_event(OP_REPORT, 1'b0, 8'hFF, 1'b1);   // full neighbor quality
        send_event(OP_REPORT, 1'b1, 8'h00, 1'b1);   // present but zero
        send_event(OP_REPORT, 1'b0, 8'hFF, 1'b1);
    endtask

    // Main sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: broken start, neighbor extremes, then warmup into steady state
        send_event(OP_HELLO,  1'b0, 8'hFF, 1'b1);
        send_event(OP_REPORT, 1'b1, 8'hFF, 1'b1);
        send_event(OP_REPORT, 1'b0, 8'h00, 1'b1);
        send_event(OP_REPORT, 1'b0, 8'h80, 1'b0);
        send_event(OP_REPORT, 1'b0, 8'h01, 1'b1);   // tiny neighbor quality
        send_event(OP_REPORT, 1'b0, 8'hFF, 1'b1);
        for (int k = 0; k < 14; k++)
            send_event(OP_HELLO, (k == 5) || (k == 12), 8'(k * 37), k[1]);
        send_event(OP_REPORT, 1'b1, 8'hC8, 1'b1);
        send_event(OP_HELLO,  1'b1, 8'h00, 1'b0);
        drain();

        // Fastest aging, no threshold: zero product without a broken flag
        load_registers(65535, 65536, 0, 4194304);
        poke_extremes();
        random_burst(90, 1'b0);

        // Slowest aging, gain above one, threshold at the maximum, limit of one; no idling
        calm = 1'b1;
        load_registers(1, 131071, 65535, 1);
        poke_extremes();
        random_burst(80, 1'b0);
        calm = 1'b0;

        // Frozen quality, zero gain, zero limit
        load_registers(0, 0, 6554, 0);
        poke_extremes();
        random_burst(80, 1'b0);

        // Random registers; receiver holds off long, sender pauses once
        load_registers($urandom_range(65535, 1), $urandom_range(65536),
                       $urandom_range(20000), $urandom_range(4194304, 1));
        hold_asked = 1'b1;
        random_burst(130, 1'b1);

        // Back to the reset settings
        load_registers(AGING_RATE_RST, LOSS_MULT_RST, MIN_QUALITY_RST, COST_LIMIT_RST);
        poke_extremes();
        random_burst(120, 1'b0);

        repeat (100) @(posedge aclk);
        if (cost_pred.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin
        #6ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
